[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bgca_pkg.sv]
// shared types and constants for the group count argmax block
`timescale 1ns / 1ps
package bgca_pkg;

  localparam int COUNT_W       = 8;
  localparam int CLASS_W       = 4;
  localparam int LANE_OUT_W    = 6;
  localparam int CLASS_LIMIT_W = 5;
  localparam int BITS_W        = 8;
  localparam int WORD_W        = 64;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_WORDS = 4'd1;

  localparam logic [CLASS_LIMIT_W-1:0] CLASS_LIMIT_RST = 5'd10;
  localparam logic [BITS_W-1:0]        CLASS_WORDS_RST = 8'd64;

  typedef logic [CLASS_W-1:0] class_t;

  typedef struct packed {
    logic   step;
    logic   class_end;
    logic   batch_end;
    class_t class_pos;
  } bgca_ctl_t;

endpackage

[rtl/bgca_lane.sv]
// one lane: per-class bit count and running best class
`timescale 1ns / 1ps
module bgca_lane
  import bgca_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bgca_ctl_t ctl,
  input  logic      bit_in,
  output class_t    win_class
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] best_count_r, best_count_nxt;
  class_t             best_class_r, best_class_nxt;
  logic [COUNT_W-1:0] new_count;
  logic               better;

  assign new_count = count_r + COUNT_W'(bit_in);
  assign better    = new_count > best_count_r;
  assign win_class = better ? ctl.class_pos : best_class_r;

  always_comb begin
    count_nxt      = count_r;
    best_count_nxt = best_count_r;
    best_class_nxt = best_class_r;
    if (ctl.step) begin
      if (ctl.class_end) begin
        count_nxt = '0;
        if (ctl.batch_end) begin
          best_count_nxt = '0;
          best_class_nxt = '0;
        end else if (better) begin
          best_count_nxt = new_count;
          best_class_nxt = ctl.class_pos;
        end
      end else begin
        count_nxt = new_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      best_count_r <= '0;
      best_class_r <= '0;
    end else begin
      count_r      <= count_nxt;
      best_count_r <= best_count_nxt;
      best_class_r <= best_class_nxt;
    end
  end

endmodule

[rtl/bgca_drain.sv]
// result buffer that takes all lane winners at once and sends one lane per beat
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bgca_drain
  import bgca_pkg::*;
#(
  parameter int LANES = 64
)(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [LANES-1:0][CLASS_W-1:0] load_class,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LANE_OUT_W-1:0]      out_lane,
  output logic [CLASS_W-1:0]         out_class_index,
  output logic                       out_last
);

  localparam int IDX_W = $clog2(LANES);
  localparam logic [IDX_W-1:0] LAST_LANE = IDX_W'(LANES - 1);

  logic                          valid_r, valid_nxt;
  logic [IDX_W-1:0]              lane_r, lane_nxt;
  logic [LANES-1:0][CLASS_W-1:0] buf_r;
  logic                          beat;

  assign beat            = valid_r && out_ready;
  assign out_valid       = valid_r;
  assign out_lane        = LANE_OUT_W'(lane_r);
  assign out_class_index = buf_r[0];
  assign out_last        = lane_r == LAST_LANE;
  assign busy            = valid_r && !(out_ready && out_last);

  always_comb begin
    valid_nxt = valid_r;
    lane_nxt  = lane_r;
    if (load) begin
      valid_nxt = 1'b1;
      lane_nxt  = '0;
    end else if (beat) begin
      if (out_last) begin
        valid_nxt = 1'b0;
      end else begin
        lane_nxt = lane_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lane_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= load_class;
    end else if (beat) begin
      for (int i = 0; i < LANES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  `ASSERT_CLK(a_load_when_free, load |-> !busy, "load while results still pending")
  `ASSERT_CLK(a_done_after_last, (beat && out_last && !load) |=> !valid_r, "drain did not stop")
  `ASSERT_CLK(a_lane_steps, (beat && !out_last && !load) |=> (lane_r == $past(lane_r) + IDX_W'(1)),
    "lane index skipped")

endmodule

[rtl/bitsliced_group_count_argmax_top.sv]
// top level: config registers, class and word counters, lanes and result drain
//
// in channel: one beat carries one 64-bit word, bit j for lane j; bits at and
// above LANES are ignored. words come class-major, class_words words per
// class, class_limit classes per batch (max MAX_CLASSES); 0 in either is 1.
// cfg channel: cfg_index 0 writes class_limit, 1 writes class_words; other
// indexes are accepted and ignored. cfg_ready is always high.
// out channel: after the last word of a batch, LANES beats follow, lanes 0 to
// LANES-1 in order, each with the lane's winning class; out_last marks the
// final lane. the first beat is valid the cycle after that word is accepted.
// throughput: one word per cycle. the per-lane counters update in parallel,
// so only a batch-ending word can stall: it waits while the drain buffer
// still holds the previous batch, which empties one lane per out beat.
// words that do not end a batch keep flowing while out stalls.
// reset: synchronous, clears all counts and positions, class_limit to 10,
// class_words to 64, and drops any pending results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bitsliced_group_count_argmax_top
  import bgca_pkg::*;
#(
  parameter int LANES       = 64,
  parameter int MAX_CLASSES = 16
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WORD_W-1:0]     in_out_bits,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LANE_OUT_W-1:0] out_lane,
  output logic [CLASS_W-1:0]    out_class_index,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [CLASS_LIMIT_W-1:0] MAX_CLS = CLASS_LIMIT_W'(MAX_CLASSES);

  logic [CLASS_LIMIT_W-1:0] class_limit_r, class_limit_nxt;
  logic [BITS_W-1:0]        class_words_r, class_words_nxt;
  logic [BITS_W-1:0]        bit_pos_r, bit_pos_nxt;
  class_t                   class_pos_r, class_pos_nxt;

  logic [CLASS_LIMIT_W-1:0] classes;
  logic [BITS_W-1:0]        words;
  logic                     class_end, batch_end, accept, drain_busy;
  bgca_ctl_t                ctl;
  logic [LANES-1:0][CLASS_W-1:0] win_class;

  assign cfg_ready = 1'b1;

  always_comb begin
    class_limit_nxt = class_limit_r;
    class_words_nxt = class_words_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLASS_LIMIT: class_limit_nxt = cfg_data[CLASS_LIMIT_W-1:0];
        CFG_CLASS_WORDS: class_words_nxt = cfg_data[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (class_limit_r == '0) begin
      classes = CLASS_LIMIT_W'(1);
    end else if (class_limit_r > MAX_CLS) begin
      classes = MAX_CLS;
    end else begin
      classes = class_limit_r;
    end
    words = (class_words_r == '0) ? BITS_W'(1) : class_words_r;
  end

  assign class_end = ({1'b0, bit_pos_r} + (BITS_W+1)'(1)) >= {1'b0, words};
  assign batch_end = class_end &&
                     (({1'b0, class_pos_r} + CLASS_LIMIT_W'(1)) >= classes);
  assign in_ready  = !(batch_end && drain_busy);
  assign accept    = in_valid && in_ready;

  assign ctl.step      = accept;
  assign ctl.class_end = class_end;
  assign ctl.batch_end = batch_end;
  assign ctl.class_pos = class_pos_r;

  always_comb begin
    bit_pos_nxt   = bit_pos_r;
    class_pos_nxt = class_pos_r;
    if (accept) begin
      if (class_end) begin
        bit_pos_nxt   = '0;
        class_pos_nxt = batch_end ? '0 : class_pos_r + CLASS_W'(1);
      end else begin
        bit_pos_nxt = bit_pos_r + BITS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_limit_r <= CLASS_LIMIT_RST;
      class_words_r <= CLASS_WORDS_RST;
      bit_pos_r     <= '0;
      class_pos_r   <= '0;
    end else begin
      class_limit_r <= class_limit_nxt;
      class_words_r <= class_words_nxt;
      bit_pos_r     <= bit_pos_nxt;
      class_pos_r   <= class_pos_nxt;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bgca_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .bit_in    (in_out_bits[g]),
      .win_class (win_class[g])
    );
  end

  bgca_drain #(
    .LANES (LANES)
  ) u_drain (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (accept && batch_end),
    .load_class      (win_class),
    .busy            (drain_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lane        (out_lane),
    .out_class_index (out_class_index),
    .out_last        (out_last)
  );

  `ASSERT_NEXT(a_batch_out, accept && batch_end, out_valid && out_lane == '0,
    "batch end gave no results")
  `ASSERT_NEXT(a_class_restart, accept && class_end, bit_pos_r == '0,
    "word position not cleared at class end")

endmodule
